### rtl/dtsp_pkg.sv
// Shared types and constants of the distance-tiered sync pacer.
// Depends on nothing; every other file of the block imports it.
package dtsp_pkg;

   localparam int SLOT_W     = 10;
   localparam int DIST_W     = 24;
   localparam int TIME_W     = 32;
   localparam int TIER_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   // wide enough for any slot count up to 65536
   localparam int SLOT_CMP_W = 17;

   localparam logic OP_CHECK = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [TIER_W-1:0] TIER_NEAR    = 2'd0;
   localparam logic [TIER_W-1:0] TIER_MEDIUM  = 2'd1;
   localparam logic [TIER_W-1:0] TIER_FAR     = 2'd2;
   localparam logic [TIER_W-1:0] TIER_DORMANT = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_LIMIT      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEDIUM_LIMIT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_LIMIT       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_INTERVAL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MEDIUM_INTERVAL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_INTERVAL    = 3'd5;

   typedef struct packed {
      logic              operation;
      logic [SLOT_W-1:0] entity_slot;
      logic [DIST_W-1:0] distance;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic              sync_now;
      logic [TIER_W-1:0] tier;
   } rsp_type;

endpackage

### rtl/dtsp_csr.sv
// Configuration registers and the distance-to-tier classifier.
// Depends on dtsp_pkg.
module dtsp_csr
   import dtsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [DIST_W-1:0]     distance,
   output logic [TIER_W-1:0]     tier,
   output logic [TIME_W-1:0]     interval
);

   logic [DIST_W-1:0] near_limit_ff, medium_limit_ff, far_limit_ff;
   logic [TIME_W-1:0] near_ivl_ff, medium_ivl_ff, far_ivl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_limit_ff   <= '0;
         medium_limit_ff <= '0;
         far_limit_ff    <= '0;
         near_ivl_ff     <= '0;
         medium_ivl_ff   <= '0;
         far_ivl_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NEAR_LIMIT:      near_limit_ff   <= csr_wdata[DIST_W-1:0];
            CSR_MEDIUM_LIMIT:    medium_limit_ff <= csr_wdata[DIST_W-1:0];
            CSR_FAR_LIMIT:       far_limit_ff    <= csr_wdata[DIST_W-1:0];
            CSR_NEAR_INTERVAL:   near_ivl_ff     <= csr_wdata[TIME_W-1:0];
            CSR_MEDIUM_INTERVAL: medium_ivl_ff   <= csr_wdata[TIME_W-1:0];
            CSR_FAR_INTERVAL:    far_ivl_ff      <= csr_wdata[TIME_W-1:0];
            default: ;  // unknown index: ignored
         endcase
      end
   end

   // first limit that covers the distance wins; limits need not be ordered
   always_comb begin
      if (distance <= near_limit_ff) begin
         tier     = TIER_NEAR;
         interval = near_ivl_ff;
      end else if (distance <= medium_limit_ff) begin
         tier     = TIER_MEDIUM;
         interval = medium_ivl_ff;
      end else if (distance <= far_limit_ff) begin
         tier     = TIER_FAR;
         interval = far_ivl_ff;
      end else begin
         tier     = TIER_DORMANT;
         interval = far_ivl_ff;  // unused for dormant
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (tier == TIER_NEAR) |-> (distance <= near_limit_ff))
      else $error("near tier chosen above near limit");

   assert property (@(posedge clock) disable iff (reset)
      (tier == TIER_DORMANT) |-> (distance > far_limit_ff && distance > near_limit_ff))
      else $error("dormant tier chosen within a limit");

   assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_index == CSR_FAR_INTERVAL) |=> (far_ivl_ff == $past(csr_wdata)))
      else $error("far interval write lost");

endmodule

### rtl/dtsp_table.sv
// Last-sync-time table: one synchronous memory, reset clearing sweep and
// write-to-read forwarding for back-to-back beats on the same slot.
// Depends on dtsp_pkg.
module dtsp_table
   import dtsp_pkg::*;
#(
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [TIME_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [TIME_W-1:0] wr_data,
   output logic              clearing
);

   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   logic [TIME_W-1:0] last_sync_ff [DEPTH];
   logic [TIME_W-1:0] rd_q_ff;
   logic [TIME_W-1:0] fwd_data_ff;
   logic              fwd_hit_ff;
   logic              clear_active_ff;
   logic [AW-1:0]     clear_addr_ff;

   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [TIME_W-1:0] mem_wd;

   always_comb begin
      if (clear_active_ff) begin
         mem_we = 1'b1;
         mem_wa = clear_addr_ff;
         mem_wd = '0;
      end else begin
         mem_we = wr_en;
         mem_wa = wr_addr;
         mem_wd = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         last_sync_ff[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_q_ff <= last_sync_ff[rd_addr];
      end
   end

   // memory returns the old word on a same-cycle collision; keep the new one
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff      <= 1'b0;
         clear_active_ff <= 1'b1;
         clear_addr_ff   <= '0;
      end else begin
         if (rd_en) begin
            fwd_hit_ff <= wr_en && (wr_addr == rd_addr);
         end
         if (clear_active_ff) begin
            clear_addr_ff <= clear_addr_ff + AW'(1);
            if (clear_addr_ff == LAST_ADDR) begin
               clear_active_ff <= 1'b0;
            end
         end
      end
      if (rd_en) begin
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data  = fwd_hit_ff ? fwd_data_ff : rd_q_ff;
   assign clearing = clear_active_ff;

   assert property (@(posedge clock) disable iff (reset)
      clear_active_ff |-> !wr_en)
      else $error("table write during clearing sweep");

   assert property (@(posedge clock) disable iff (reset)
      clear_active_ff |-> !rd_en)
      else $error("table read during clearing sweep");

   assert property (@(posedge clock) disable iff (reset)
      $fell(clear_active_ff) |-> ($past(clear_addr_ff) == LAST_ADDR))
      else $error("clearing sweep ended early");

endmodule

### rtl/distance_tiered_sync_pacer_top.sv
// Distance-tiered sync pacer, top level: request stage, table decision stage,
// response register. Depends on dtsp_pkg, dtsp_csr and dtsp_table.
//
// Order: a taken beat is registered into the decision stage, then into the
//   response register, which drives rsp_valid.
// Throughput: one beat per cycle while busy is low; the table does one read
//   and one write per cycle, with forwarding between consecutive beats on one slot.
// Reset: synchronous; then busy stays high while a sweep zeroes the table.
//   Config registers reset to 0 and may be written meanwhile.
// The receiver cannot stall: each response is valid for exactly one cycle.
module distance_tiered_sync_pacer_top
   import dtsp_pkg::*;
#(
   parameter int ENTITY_SLOTS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   // response channel
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   // configuration write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = (ENTITY_SLOTS > 1) ? $clog2(ENTITY_SLOTS) : 1;
   localparam logic [SLOT_CMP_W-1:0] SLOT_COUNT = SLOT_CMP_W'(ENTITY_SLOTS);

   // ---- request stage: classify and launch the table read ----
   logic                  accept;
   logic                  clearing;
   logic [TIER_W-1:0]     tier;
   logic [TIME_W-1:0]     interval;
   logic [SLOT_CMP_W-1:0] slot_wide;
   logic [AW-1:0]         rd_addr;
   logic                  in_range;

   assign busy      = reset | clearing;
   assign accept    = start && !busy;
   assign slot_wide = SLOT_CMP_W'(req_data.entity_slot);
   assign rd_addr   = slot_wide[AW-1:0];
   assign in_range  = slot_wide < SLOT_COUNT;  // out-of-range slots are read but never write the table

   dtsp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .distance  (req_data.distance),
      .tier      (tier),
      .interval  (interval)
   );

   // ---- decision stage registers ----
   logic              s1_valid_ff;
   logic              s1_op_ff;
   logic              s1_in_range_ff;
   logic [AW-1:0]     s1_addr_ff;
   logic [TIER_W-1:0] s1_tier_ff;
   logic [TIME_W-1:0] s1_interval_ff;
   logic [TIME_W-1:0] s1_now_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_op_ff       <= req_data.operation;
         s1_in_range_ff <= in_range;
         s1_addr_ff     <= rd_addr;
         // a clear answers with tier near
         s1_tier_ff     <= (req_data.operation == OP_CLEAR) ? TIER_NEAR : tier;
         s1_interval_ff <= interval;
         s1_now_ff      <= req_data.now_ms;
      end
   end

   // ---- table ----
   logic [TIME_W-1:0] last_time;
   logic              wr_en;
   logic [TIME_W-1:0] wr_data;

   dtsp_table #(
      .DEPTH (ENTITY_SLOTS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (rd_addr),
      .rd_data  (last_time),
      .wr_en    (wr_en),
      .wr_addr  (s1_addr_ff),
      .wr_data  (wr_data),
      .clearing (clearing)
   );

   // ---- decision: due when never synced or now has reached last + interval ----
   logic [TIME_W-1:0] due_time;
   logic              due;
   logic              sync_now;

   assign due_time = last_time + s1_interval_ff;  // wraps mod 2^32
   assign due      = (last_time == '0) || (s1_now_ff >= due_time);
   assign sync_now = (s1_op_ff == OP_CHECK) && (s1_tier_ff != TIER_DORMANT)
                     && s1_in_range_ff && due;

   assign wr_en   = s1_valid_ff && s1_in_range_ff && ((s1_op_ff == OP_CLEAR) || sync_now);
   assign wr_data = (s1_op_ff == OP_CLEAR) ? '0 : s1_now_ff;

   // ---- response register ----
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (s1_valid_ff) begin
         rsp_data_ff.sync_now <= sync_now;
         rsp_data_ff.tier     <= s1_tier_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid_ff)
      else $error("accepted beat produced no response");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.sync_now) |-> (rsp_data_ff.tier != TIER_DORMANT))
      else $error("dormant entity reported as syncing");

   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_op_ff == OP_CLEAR) |=> (!rsp_data_ff.sync_now))
      else $error("clear answered with sync");

   assert property (@(posedge clock) disable iff (reset)
      clearing |-> !s1_valid_ff)
      else $error("beat in flight during clearing sweep");

endmodule

### verif/distance_tiered_sync_pacer_top_tb.sv
// Self-checking testbench for distance_tiered_sync_pacer_top: a scoreboard class predicts
// each sync decision; plain tasks drive request beats and program the registers.
// Depends on dtsp_pkg and the RTL of the block only.
module distance_tiered_sync_pacer_top_tb;
   import dtsp_pkg::*;

   localparam int          SLOT_COUNT  = 1024;
   // a response passes the decision stage and the response register; settle a little longer
   localparam int          SETTLE_WAIT = 4;
   // reset + clear sweep + ~1650 beats with gaps stay far below this
   localparam int unsigned CYCLE_LIMIT = 300_000;
   localparam int          RAND_PHASES = 8;
   localparam int          PHASE_BEATS = 200;

   // register indexes the block decodes to nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Predicts the sync decision of every accepted beat and keeps the decisions
   // in arrival order; the response monitor retires them one per strobe.
   class sync_decision_board;
      logic [DIST_W-1:0] limit_near, limit_medium, limit_far;
      logic [TIME_W-1:0] gap_near, gap_medium, gap_far;
      logic [TIME_W-1:0] last_sent [SLOT_COUNT];
      rsp_type           decisions_q [$];
      int unsigned       mismatches, beats, syncs, dormants, clears;

      function new();
         limit_near   = '0;
         limit_medium = '0;
         limit_far    = '0;
         gap_near     = '0;
         gap_medium   = '0;
         gap_far      = '0;
         foreach (last_sent[i]) last_sent[i] = '0;
         mismatches = 0;
         beats      = 0;
         syncs      = 0;
         dormants   = 0;
         clears     = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_NEAR_LIMIT:      limit_near   = data[DIST_W-1:0];
            CSR_MEDIUM_LIMIT:    limit_medium = data[DIST_W-1:0];
            CSR_FAR_LIMIT:       limit_far    = data[DIST_W-1:0];
            CSR_NEAR_INTERVAL:   gap_near     = data[TIME_W-1:0];
            CSR_MEDIUM_INTERVAL: gap_medium   = data[TIME_W-1:0];
            CSR_FAR_INTERVAL:    gap_far      = data[TIME_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(req_type r);
         rsp_type           d;
         logic [TIME_W-1:0] gap;
         logic [TIME_W-1:0] due;
         logic              in_range;
         in_range   = int'(r.entity_slot) < SLOT_COUNT;
         d.sync_now = 1'b0;
         d.tier     = TIER_NEAR;
         beats++;
         if (r.operation == OP_CLEAR) begin
            if (in_range) last_sent[r.entity_slot] = '0;
            clears++;
         end else begin
            if (r.distance <= limit_near)        d.tier = TIER_NEAR;
            else if (r.distance <= limit_medium) d.tier = TIER_MEDIUM;
            else if (r.distance <= limit_far)    d.tier = TIER_FAR;
            else                                 d.tier = TIER_DORMANT;
            if (d.tier == TIER_DORMANT) dormants++;
            if (d.tier != TIER_DORMANT && in_range) begin
               case (d.tier)
                  TIER_NEAR:   gap = gap_near;
                  TIER_MEDIUM: gap = gap_medium;
                  default:     gap = gap_far;
               endcase
               due = last_sent[r.entity_slot] + gap;   // wraps at 2^32
               if (last_sent[r.entity_slot] == '0 || r.now_ms >= due) begin
                  last_sent[r.entity_slot] = r.now_ms;
                  d.sync_now = 1'b1;
                  syncs++;
               end
            end
         end
         decisions_q.push_back(d);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (decisions_q.size() == 0) begin
            $error("unexpected response: sync_now=%0b tier=%0d", got.sync_now, got.tier);
            mismatches++;
            return;
         end
         want = decisions_q.pop_front();
         if (got.sync_now !== want.sync_now) begin
            $error("sync_now: expected %0b, actual %0b", want.sync_now, got.sync_now);
            mismatches++;
         end
         if (got.tier !== want.tier) begin
            $error("tier: expected %0d, actual %0d", want.tier, got.tier);
            mismatches++;
         end
      endfunction
   endclass

   sync_decision_board board;
   logic [TIME_W-1:0]  wall_ms;      // running clock of the random traffic
   int unsigned        step_max;     // largest wall clock advance per beat
   int unsigned        setups;
   int unsigned        cycles = 0;

   distance_tiered_sync_pacer_top #(
      .ENTITY_SLOTS(SLOT_COUNT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Watchdog: a hung handshake or missing response ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Response monitor. The receiver never stalls, so every strobe is a beat;
   // values are read at the edge, before this edge's updates land.
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_response(rsp_data);
   end

   function automatic req_type beat_of(logic op, logic [SLOT_W-1:0] slot,
                                       logic [DIST_W-1:0] dist_fp, logic [TIME_W-1:0] now);
      req_type b;
      b.operation   = op;
      b.entity_slot = slot;
      b.distance    = dist_fp;
      b.now_ms      = now;
      return b;
   endfunction

   // Holds start high with the beat until an edge sees busy low. A following
   // call in the same step keeps start high, so back-to-back beats never dip.
   task automatic drive_beat(req_type b);
      start    <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (busy !== 1'b0);
      board.note_request(b);
   endtask

   // Sender gap; junk on the request bus must be ignored while start is low.
   task automatic pause(int unsigned n);
      logic [95:0] junk;
      start <= 1'b0;
      repeat (n) begin
         junk     = {$urandom, $urandom, $urandom};
         req_data <= req_type'(junk[$bits(req_type)-1:0]);
         @(posedge clock);
      end
   endtask

   // Wait for every predicted decision to come back, then let the pipe empty.
   task automatic settle();
      start <= 1'b0;
      while (board.decisions_q.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // csr_we stays high across consecutive writes; apply_setup lowers it once.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      board.set_reg(idx, data);
   endtask

   task automatic apply_setup(logic [CSR_DATA_W-1:0] n_lim, m_lim, f_lim,
                              n_gap, m_gap, f_gap);
      write_reg(CSR_NEAR_LIMIT, n_lim);
      write_reg(CSR_UNUSED_LO, $urandom);
      write_reg(CSR_MEDIUM_LIMIT, m_lim);
      write_reg(CSR_FAR_LIMIT, f_lim);
      write_reg(CSR_NEAR_INTERVAL, n_gap);
      write_reg(CSR_MEDIUM_INTERVAL, m_gap);
      write_reg(CSR_FAR_INTERVAL, f_gap);
      write_reg(CSR_UNUSED_HI, $urandom);
      csr_we <= 1'b0;
      setups++;
   endtask

   // Mostly a handful of hot slots on an advancing clock, so intervals are
   // actually hit; distances cluster on the tier edges.
   function automatic req_type make_item();
      req_type b;
      b.operation   = ($urandom_range(0, 9) == 0) ? OP_CLEAR : OP_CHECK;
      b.entity_slot = ($urandom_range(0, 3) != 0) ? SLOT_W'($urandom_range(0, 7))
                                                  : SLOT_W'($urandom);
      case ($urandom_range(0, 5))
         0: b.distance = DIST_W'($urandom);
         1: b.distance = board.limit_near   + DIST_W'($urandom_range(0, 2)) - DIST_W'(1);
         2: b.distance = board.limit_medium + DIST_W'($urandom_range(0, 2)) - DIST_W'(1);
         3: b.distance = board.limit_far    + DIST_W'($urandom_range(0, 2)) - DIST_W'(1);
         default: b.distance = DIST_W'($urandom_range(0, board.limit_far));
      endcase
      wall_ms  = wall_ms + $urandom_range(0, step_max);
      b.now_ms = ($urandom_range(0, 19) == 0) ? TIME_W'($urandom) : wall_ms;
      return b;
   endfunction

   // Bursts of random length, mostly short, sometimes long with no gaps.
   task automatic run_random(int unsigned count);
      int unsigned burst_left;
      burst_left = $urandom_range(1, 12);
      for (int unsigned k = 0; k < count; k++) begin
         drive_beat(make_item());
         burst_left--;
         if (burst_left == 0) begin
            pause($urandom_range(1, 6));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
         end
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] lim_a, lim_b, lim_c;
      board     = new();
      setups    = 0;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      wall_ms   = 32'd2000;
      step_max  = 60;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Junk in the upper byte of the near limit must be dropped.
      // The block sweeps its table after reset; the first beat waits on busy.
      apply_setup(32'hA500_0100, 32'h0000_1000, 32'h0001_0000, 32'd10, 32'd50, 32'd200);
      drive_beat(beat_of(OP_CHECK, 10'd0, 24'h000000, 32'd1000));   // never synced
      drive_beat(beat_of(OP_CHECK, 10'd0, 24'h000000, 32'd1005));   // too early
      drive_beat(beat_of(OP_CHECK, 10'd0, 24'h000100, 32'd1010));   // near edge, due
      drive_beat(beat_of(OP_CHECK, 10'd0, 24'h000101, 32'd1050));   // medium, early
      drive_beat(beat_of(OP_CHECK, 10'd0, 24'h001000, 32'd1060));   // medium edge, due
      drive_beat(beat_of(OP_CHECK, 10'd1, 24'h010000, 32'd5));      // far edge
      pause(3);
      drive_beat(beat_of(OP_CHECK, 10'd1, 24'h010001, 32'd9999));   // dormant
      drive_beat(beat_of(OP_CHECK, 10'd1, 24'hFFFFFF, 32'hFFFFFFFF));
      drive_beat(beat_of(OP_CLEAR, 10'd0, 24'hABCDEF, 32'h1234_5678));
      drive_beat(beat_of(OP_CHECK, 10'd0, 24'h000200, 32'd1061));   // forgotten, syncs
      drive_beat(beat_of(OP_CHECK, 10'd1023, 24'h000000, 32'd0));   // sync at time zero
      drive_beat(beat_of(OP_CHECK, 10'd1023, 24'h000000, 32'd0));   // still never synced
      drive_beat(beat_of(OP_CHECK, 10'd1022, 24'h000000, 32'hFFFFFFFF));
      drive_beat(beat_of(OP_CHECK, 10'd1022, 24'h000000, 32'd5));   // due wrapped to 9
      drive_beat(beat_of(OP_CHECK, 10'd1022, 24'h000000, 32'd9));
      drive_beat(beat_of(OP_CLEAR, 10'd1023, 24'h000000, 32'd0));
      drive_beat(beat_of(OP_CLEAR, 10'd1023, 24'hFFFFFF, 32'hFFFFFFFF));
      drive_beat(beat_of(OP_CHECK, 10'd1023, 24'h00FFFF, 32'd7));
      drive_beat(beat_of(OP_CHECK, 10'd512, 24'h000080, 32'h8000_0000));
      drive_beat(beat_of(OP_CHECK, 10'd512, 24'h000080, 32'h7FFF_FFFF)); // clock went back
      // pipe drains with no beats pending; nothing may trail out
      settle();

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph)
            0: begin   // everything within range, intervals at their largest
               apply_setup(32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
               step_max = 40;
            end
            1: begin   // only distance zero is near, the rest dormant; intervals are zero
               apply_setup('0, '0, '0, '0, '0, '0);
               step_max = 5;
            end
            2: begin   // limits out of order: medium shadowed by near
               apply_setup(32'h0000_8000, 32'h0000_0100, 32'h0002_0000,
                           $urandom_range(0, 300), $urandom_range(0, 300),
                           $urandom_range(0, 300));
               step_max = 80;
            end
            default: begin
               lim_a = $urandom_range(0, 32'h3FFF);
               lim_b = lim_a + $urandom_range(0, 32'h3FFFF);
               lim_c = lim_b + $urandom_range(0, 32'hFFFFF);
               if (ph == RAND_PHASES - 1) begin   // fully random, unordered
                  lim_a = $urandom_range(0, 32'hFFFFFF);
                  lim_b = $urandom_range(0, 32'hFFFFFF);
                  lim_c = $urandom_range(0, 32'hFFFFFF);
               end
               apply_setup(lim_a | ($urandom & 32'hFF00_0000),
                           lim_b | ($urandom & 32'hFF00_0000),
                           lim_c | ($urandom & 32'hFF00_0000),
                           (ph == 5) ? $urandom : $urandom_range(0, 400),
                           (ph == 5) ? $urandom : $urandom_range(0, 400),
                           (ph == 5) ? $urandom : $urandom_range(0, 400));
               step_max = 100;
            end
         endcase
         // one phase runs the wall clock through the 32-bit wrap
         if (ph == 6) wall_ms = 32'hFFFF_FE00;
         run_random(PHASE_BEATS);
         settle();
      end

      $display("Ran %0d beats over %0d register settings: %0d syncs, %0d dormant, %0d clears.",
               board.beats, setups, board.syncs, board.dormants, board.clears);
      if (board.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
